### hdl/dual_channel_adc_averager_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual channel ADC averager
// Each macro expects clk and arst_n in scope; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_ADC_AVERAGER_UNIT_ASSERT_SVH
`define DUAL_CHANNEL_ADC_AVERAGER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge outside reset
`define DCAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DCAA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DCAA_ASSERT(lbl, prop, msg)
`define DCAA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/dcaa_pkg.sv
// ----------------------------------------------------------------------------
// dcaa_pkg
// Shared widths, reset values, register codes, command and status types.
// ----------------------------------------------------------------------------
package dcaa_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int SUM_EXTRA       = 8;   // sum width = sample width + 8
	localparam int QW_EXTRA        = 10;  // scaled sum width = sample width + 10
	localparam int CNT_W           = 8;
	localparam int GAIN_W          = 4;
	localparam int AVG_W           = 12;
	localparam int DIG_W           = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;
	localparam int DIG_STEPS       = 3;
	localparam int WIDE_W          = 14;  // holds nine times a thousand

	localparam int W_THOU = 1000;
	localparam int W_HUND = 100;
	localparam int W_TEN  = 10;

	localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 8'd250;
	localparam logic [GAIN_W-1:0] VGAIN_RST        = 4'd11;
	localparam logic [GAIN_W-1:0] CGAIN_RST        = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT = 2'd0,
		REG_VOLTAGE_GAIN = 2'd1,
		REG_CURRENT_GAIN = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIG_THOUSANDS = 2'd0,
		DIG_HUNDREDS  = 2'd1,
		DIG_TENS      = 2'd2
	} dig_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mul;
		logic     div_step;
		logic     dig_step;
		dig_sel_t dig_sel;
		logic     load_out;
	} dcaa_cmd_t;

	typedef struct packed {
		logic blk_done;
		logic out_free;
	} dcaa_sts_t;

	// largest k in 0..9 with k*w not above v
	function automatic logic [DIG_W-1:0] digit_of(logic [AVG_W-1:0] v, int unsigned w);
		logic [DIG_W-1:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({{(WIDE_W-AVG_W){1'b0}}, v} >= WIDE_W'(k * w))
				d = DIG_W'(k);
		end
		return d;
	endfunction

endpackage

### hdl/dcaa_ctrl.sv
// ----------------------------------------------------------------------------
// dcaa_ctrl
// Sequencer: accept, scale, restoring divide, digit extraction, hand-off.
// ----------------------------------------------------------------------------
`include "dual_channel_adc_averager_unit_assert.svh"

module dcaa_ctrl import dcaa_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dcaa_sts_t sts,
	output dcaa_cmd_t cmd
);

	localparam int QW     = SAMPLE_BITS + QW_EXTRA;
	localparam int STEP_W = $clog2(QW);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);
	localparam logic [STEP_W-1:0] DIG_LAST  = STEP_W'(DIG_STEPS - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_DIG  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.blk_done ? ST_MUL : ST_EMIT;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					step_d  = '0;
					state_d = ST_DIG;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DIG: begin
				cmd.dig_step = 1'b1;
				cmd.dig_sel  = dig_sel_t'(step_q[1:0]);
				if (step_q == DIG_LAST) begin
					step_d  = '0;
					state_d = ST_EMIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	`DCAA_ASSERT_NEXT(a_done_starts_scale, (cmd.accept && sts.blk_done), state_q == ST_MUL, "completing item did not start scaling")
	`DCAA_ASSERT_NEXT(a_plain_goes_emit, (cmd.accept && !sts.blk_done), state_q == ST_EMIT, "plain item did not go straight to hand-off")
	`DCAA_ASSERT(a_load_needs_slot, cmd.load_out |-> sts.out_free, "output loaded while occupied and stalled")

endmodule

### hdl/dcaa_dpath.sv
// ----------------------------------------------------------------------------
// dcaa_dpath
// Config registers, per-channel sums and counts, scaler, divider, digits and
// the output register.
// ----------------------------------------------------------------------------
`include "dual_channel_adc_averager_unit_assert.svh"

module dcaa_dpath import dcaa_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  dcaa_cmd_t              cmd,
	output dcaa_sts_t              sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   next_channel,
	output logic                   done_res,
	output logic                   done_channel,
	output logic [AVG_W-1:0]       average,
	output logic [DIG_W-1:0]       digit_thousands,
	output logic [DIG_W-1:0]       digit_hundreds,
	output logic [DIG_W-1:0]       digit_tens
);

	localparam int SUM_W  = SAMPLE_BITS + SUM_EXTRA;
	localparam int QW     = SAMPLE_BITS + QW_EXTRA;
	localparam int PROD_W = SUM_W + GAIN_W;
	localparam int DIV_W  = CNT_W + 1;

	// configuration
	logic [CNT_W-1:0]  cfg_count_q;
	logic [GAIN_W-1:0] cfg_vgain_q, cfg_cgain_q;

	// accumulation state
	logic              flag_q;
	logic [SUM_W-1:0]  sum_cur_q, sum_volt_q;
	logic [CNT_W-1:0]  cnt_cur_q, cnt_volt_q;

	// work registers
	logic              chan_q, next_q, done_q;
	logic [GAIN_W-1:0] gain_q;
	logic [QW-1:0]     quo_q;
	logic [DIV_W-1:0]  div_q, rem_q;
	logic [AVG_W-1:0]  avg_q, vrem_q;
	logic [DIG_W-1:0]  dth_q, dhu_q, dte_q;

	// output register
	logic              out_valid_q;
	logic              out_next_q, out_done_q, out_chan_q;
	logic [AVG_W-1:0]  out_avg_q;
	logic [DIG_W-1:0]  out_dth_q, out_dhu_q, out_dte_q;

	logic [SUM_W-1:0]  sum_sel, sum_new;
	logic [CNT_W-1:0]  cnt_sel;
	logic [DIV_W-1:0]  cnt_new, blk_len;
	logic              blk_done;
	logic [PROD_W-1:0] prod;
	logic [DIV_W:0]    rem_sh;
	logic              q_bit;
	logic [AVG_W-1:0]  sat, dig_in, dig_rem;
	logic [DIG_W-1:0]  dig_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= SAMPLE_COUNT_RST;
			cfg_vgain_q <= VGAIN_RST;
			cfg_cgain_q <= CGAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAMPLE_COUNT: cfg_count_q <= cfg_data;
				REG_VOLTAGE_GAIN: cfg_vgain_q <= cfg_data[GAIN_W-1:0];
				REG_CURRENT_GAIN: cfg_cgain_q <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a block length of zero stands for a full 256
	always_comb begin
		sum_sel  = flag_q ? sum_volt_q : sum_cur_q;
		cnt_sel  = flag_q ? cnt_volt_q : cnt_cur_q;
		sum_new  = sum_sel + SUM_W'(sample);
		cnt_new  = {1'b0, cnt_sel} + 1'b1;
		blk_len  = (cfg_count_q == '0) ? DIV_W'(1 << CNT_W) : {1'b0, cfg_count_q};
		blk_done = (cnt_new >= blk_len);
	end

	assign sts.blk_done = blk_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= 1'b0;
			sum_cur_q  <= '0;
			sum_volt_q <= '0;
			cnt_cur_q  <= '0;
			cnt_volt_q <= '0;
		end else if (cmd.accept) begin
			flag_q <= ~flag_q;
			if (flag_q) begin
				sum_volt_q <= blk_done ? '0 : sum_new;
				cnt_volt_q <= blk_done ? '0 : cnt_new[CNT_W-1:0];
			end else begin
				sum_cur_q <= blk_done ? '0 : sum_new;
				cnt_cur_q <= blk_done ? '0 : cnt_new[CNT_W-1:0];
			end
		end
	end

	assign prod   = quo_q[SUM_W-1:0] * gain_q;
	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign q_bit  = (rem_sh >= {1'b0, div_q});
	assign sat    = (|quo_q[QW-1:AVG_W]) ? '1 : quo_q[AVG_W-1:0];

	always_comb begin
		case (cmd.dig_sel)
			DIG_THOUSANDS: begin
				dig_in  = sat;
				dig_d   = digit_of(dig_in, W_THOU);
				dig_rem = dig_in - AVG_W'(int'(dig_d) * W_THOU);
			end
			DIG_HUNDREDS: begin
				dig_in  = vrem_q;
				dig_d   = digit_of(dig_in, W_HUND);
				dig_rem = dig_in - AVG_W'(int'(dig_d) * W_HUND);
			end
			DIG_TENS: begin
				dig_in  = vrem_q;
				dig_d   = digit_of(dig_in, W_TEN);
				dig_rem = dig_in - AVG_W'(int'(dig_d) * W_TEN);
			end
			default: begin
				dig_in  = vrem_q;
				dig_d   = '0;
				dig_rem = vrem_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			chan_q <= flag_q;
			next_q <= ~flag_q;
			done_q <= blk_done;
			gain_q <= flag_q ? cfg_vgain_q : cfg_cgain_q;
			quo_q  <= QW'(sum_new);
			div_q  <= cnt_new;
			avg_q  <= '0;
			dth_q  <= '0;
			dhu_q  <= '0;
			dte_q  <= '0;
		end
		if (cmd.mul) begin
			// drop the two low bits of the product
			quo_q <= prod[PROD_W-1:2];
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[QW-2:0], q_bit};
			rem_q <= q_bit ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
		end
		if (cmd.dig_step) begin
			vrem_q <= dig_rem;
			case (cmd.dig_sel)
				DIG_THOUSANDS: begin
					avg_q <= sat;
					dth_q <= dig_d;
				end
				DIG_HUNDREDS: dhu_q <= dig_d;
				DIG_TENS:     dte_q <= dig_d;
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			out_next_q <= next_q;
			out_done_q <= done_q;
			out_chan_q <= chan_q & done_q;
			out_avg_q  <= avg_q;
			out_dth_q  <= dth_q;
			out_dhu_q  <= dhu_q;
			out_dte_q  <= dte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign next_channel    = out_next_q;
	assign done_res        = out_done_q;
	assign done_channel    = out_chan_q;
	assign average         = out_avg_q;
	assign digit_thousands = out_dth_q;
	assign digit_hundreds  = out_dhu_q;
	assign digit_tens      = out_dte_q;

	`DCAA_ASSERT(a_plain_item_zero, (out_valid && !done_res) |-> (average == '0 && done_channel == 1'b0), "item without a completed block carries a result")
	`DCAA_ASSERT_NEXT(a_rem_below_divisor, cmd.div_step, rem_q < div_q, "divider remainder not below divisor")
	`DCAA_ASSERT(a_digits_decimal, out_valid |-> (digit_thousands <= 4'd4 && digit_hundreds <= 4'd9 && digit_tens <= 4'd9), "digit out of decimal range")

endmodule

### hdl/dual_channel_adc_averager_unit.sv
// ----------------------------------------------------------------------------
// dual_channel_adc_averager_unit
// Block averager for alternating current and voltage converter samples.
//
// Samples come in on in_valid/in_stall, current channel first after reset,
// then alternating. Every item yields one result on out_valid/out_stall:
// next_channel always, and when the item closes a channel's block, done_res
// with the scaled average floor(floor(sum*gain/4)/count) and its digits.
// Configuration is written on cfg_valid/cfg_ready (always ready); the user
// must write it only while idle, which the block does not enforce. An item
// that closes no block goes straight to the hand-off. One that closes a block
// goes through an accumulate, a scale multiply, SAMPLE_BITS+10 restoring
// divide steps on the shared divider, three digit steps and a hand-off. A new
// item is taken once the previous one is in the output register, so a stalled
// result is held while the next item is worked on; the hand-off then waits.
// Reset selects the current channel, clears sums and counts and loads the
// default block length and gains.
// ----------------------------------------------------------------------------
module dual_channel_adc_averager_unit import dcaa_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   next_channel,
	output logic                   done_res,
	output logic                   done_channel,
	output logic [AVG_W-1:0]       average,
	output logic [DIG_W-1:0]       digit_thousands,
	output logic [DIG_W-1:0]       digit_hundreds,
	output logic [DIG_W-1:0]       digit_tens
);

	dcaa_cmd_t cmd;
	dcaa_sts_t sts;

	dcaa_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	dcaa_dpath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_channel   (next_channel),
		.done_res       (done_res),
		.done_channel   (done_channel),
		.average        (average),
		.digit_thousands(digit_thousands),
		.digit_hundreds (digit_hundreds),
		.digit_tens     (digit_tens)
	);

endmodule

### tb/dcaa_result_checker.sv
// ----------------------------------------------------------------------------
// dcaa_result_checker
// Watches the sample, configuration and result channels of the dual channel
// ADC averager. It keeps its own copy of the channel sums, counts and
// registers, works out the result of every accepted sample and compares
// each accepted result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module dcaa_result_checker import dcaa_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [SAMPLE_BITS_DEF-1:0] sample,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       next_channel,
	input  logic                       done_res,
	input  logic                       done_channel,
	input  logic [AVG_W-1:0]           average,
	input  logic [DIG_W-1:0]           digit_thousands,
	input  logic [DIG_W-1:0]           digit_hundreds,
	input  logic [DIG_W-1:0]           digit_tens,
	output int                         fails,
	output int                         pending
);

	localparam int SUM_W  = SAMPLE_BITS_DEF + SUM_EXTRA;
	localparam int PROD_W = SUM_W + GAIN_W;

	typedef struct packed {
		logic             next_ch;
		logic             done;
		logic             done_ch;
		logic [AVG_W-1:0] avg;
		logic [DIG_W-1:0] thou;
		logic [DIG_W-1:0] hund;
		logic [DIG_W-1:0] tens;
	} avg_result_t;

	logic              sel_voltage;
	logic [SUM_W-1:0]  volt_sum;
	logic [SUM_W-1:0]  curr_sum;
	logic [CNT_W-1:0]  volt_cnt;
	logic [CNT_W-1:0]  curr_cnt;
	logic [CNT_W-1:0]  block_len_reg;
	logic [GAIN_W-1:0] volt_gain;
	logic [GAIN_W-1:0] curr_gain;

	avg_result_t expected_q[$];

	initial fails = 0;

	// add one sample to the selected channel and queue the result it causes
	function automatic void accumulate_sample(logic [SAMPLE_BITS_DEF-1:0] s);
		logic [SUM_W-1:0]  acc;
		logic [CNT_W:0]    cnt1;
		logic [CNT_W:0]    blk_len;
		logic [GAIN_W-1:0] g;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] q;
		avg_result_t       r;
		r = '0;
		// a zero block length stands for 256 samples
		blk_len = (block_len_reg == '0) ? (CNT_W+1)'(256) : {1'b0, block_len_reg};
		acc  = sel_voltage ? volt_sum + s : curr_sum + s;
		cnt1 = (sel_voltage ? {1'b0, volt_cnt} : {1'b0, curr_cnt}) + 1'b1;
		g    = sel_voltage ? volt_gain : curr_gain;
		// close the block once the count is at or above the length
		if (cnt1 >= blk_len) begin
			prod      = acc * g;
			q         = (prod >> 2) / cnt1;
			r.done    = 1'b1;
			r.done_ch = sel_voltage;
			r.avg     = (q > {AVG_W{1'b1}}) ? {AVG_W{1'b1}} : q[AVG_W-1:0];
			r.thou    = DIG_W'((r.avg / W_THOU) % 10);
			r.hund    = DIG_W'((r.avg / W_HUND) % 10);
			r.tens    = DIG_W'((r.avg / W_TEN) % 10);
			acc       = '0;
			cnt1      = '0;
		end
		if (sel_voltage) begin
			volt_sum = acc;
			volt_cnt = cnt1[CNT_W-1:0];
		end else begin
			curr_sum = acc;
			curr_cnt = cnt1[CNT_W-1:0];
		end
		sel_voltage = !sel_voltage;
		r.next_ch   = sel_voltage;
		expected_q.push_back(r);
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		avg_result_t r;
		if (!arst_n) begin
			sel_voltage   = 1'b0;
			volt_sum      = '0;
			curr_sum      = '0;
			volt_cnt      = '0;
			curr_cnt      = '0;
			block_len_reg = SAMPLE_COUNT_RST;
			volt_gain     = VGAIN_RST;
			curr_gain     = CGAIN_RST;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_COUNT: begin
						block_len_reg = cfg_data;
					end
					REG_VOLTAGE_GAIN: begin
						volt_gain = cfg_data[GAIN_W-1:0];
					end
					REG_CURRENT_GAIN: begin
						curr_gain = cfg_data[GAIN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// compare before predicting: a result never belongs to the item taken at the same edge
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result arrived with no item waiting for one", $time);
					fails++;
				end else begin
					r = expected_q.pop_front();
					check_field("next_channel", r.next_ch, next_channel);
					check_field("done_res", r.done, done_res);
					check_field("done_channel", r.done_ch, done_channel);
					check_field("average", r.avg, average);
					check_field("digit_thousands", r.thou, digit_thousands);
					check_field("digit_hundreds", r.hund, digit_hundreds);
					check_field("digit_tens", r.tens, digit_tens);
				end
			end
			if (in_valid && !in_stall)
				accumulate_sample(sample);
			pending <= expected_q.size();
		end
	end

endmodule

### tb/tb_dual_channel_adc_averager_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_channel_adc_averager_unit
// Regression for the dual channel ADC averager. A short directed run covers
// reset defaults, extreme samples, zero gain and a block length lowered
// mid-block; random phases follow with new settings between them, random
// idling on both sides and one long output hold. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_dual_channel_adc_averager_unit;
	import dcaa_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam logic [SW-1:0] SAMPLE_MAX = {SW{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [SW-1:0]         sample;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_stall;
	logic                  next_channel;
	logic                  done_res;
	logic                  done_channel;
	logic [AVG_W-1:0]      average;
	logic [DIG_W-1:0]      digit_thousands;
	logic [DIG_W-1:0]      digit_hundreds;
	logic [DIG_W-1:0]      digit_tens;

	int fails;
	int pending;
	bit idle_on;
	bit long_hold_req;
	int hold_left;

	dual_channel_adc_averager_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.next_channel    (next_channel),
		.done_res        (done_res),
		.done_channel    (done_channel),
		.average         (average),
		.digit_thousands (digit_thousands),
		.digit_hundreds  (digit_hundreds),
		.digit_tens      (digit_tens)
	);

	dcaa_result_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample          (sample),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.next_channel    (next_channel),
		.done_res        (done_res),
		.done_channel    (done_channel),
		.average         (average),
		.digit_thousands (digit_thousands),
		.digit_hundreds  (digit_hundreds),
		.digit_tens      (digit_tens),
		.fails           (fails),
		.pending         (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("dual_channel_adc_averager_unit regression: fail");
		$finish;
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				hold_left = 150;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				hold_left = $urandom_range(0, 11);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SAMPLE_MAX;
			default: return SW'($urandom_range(0, int'(SAMPLE_MAX)));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] gain_word(int gain);
		// upper bits carry noise; only the low nibble is a gain
		return {4'($urandom_range(0, 15)), 4'(gain)};
	endfunction

	task automatic push_sample(input logic [SW-1:0] s);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold the sample channel until every queued result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] len,
			input logic [CFG_DATA_W-1:0] vword, input logic [CFG_DATA_W-1:0] cword);
		drain_results();
		write_reg(REG_SAMPLE_COUNT, len);
		write_reg(REG_VOLTAGE_GAIN, vword);
		write_reg(REG_CURRENT_GAIN, cword);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int items_sent;
		int phase_no;
		int n;
		logic [CFG_DATA_W-1:0] len;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SAMPLE_COUNT;
		cfg_data  <= '0;
		idle_on   = 1'b0;
		long_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, then shorten the block so both partial blocks close
		repeat (3) push_sample(SAMPLE_MAX);
		drain_results();
		write_reg(REG_SAMPLE_COUNT, 8'd1);
		cfg_valid <= 1'b0;
		repeat (2) push_sample(SAMPLE_MAX);

		set_config(8'd1, gain_word(15), gain_word(15));
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MAX);
		push_sample('0);
		push_sample('0);
		push_sample(SW'(10'h2AA));
		push_sample(SW'(10'h155));
		push_sample(SW'(512));
		push_sample(SW'(511));

		// zero gain on voltage, unit gain on current
		set_config(8'd1, gain_word(0), gain_word(1));
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MAX);
		push_sample(SW'(1));
		push_sample(SW'(3));

		// leave the current channel mid-block, then lower the length
		set_config(8'd3, gain_word(7), gain_word(13));
		for (int i = 1; i <= 5; i++) push_sample(SW'(i));
		set_config(8'd2, gain_word(15), gain_word(15));
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MAX);

		items_sent = 0;
		phase_no = 0;
		while (items_sent < 70) begin
			case ($urandom_range(0, 4))
				0: len = 8'd1;
				1: len = 8'd2;
				2: len = 8'($urandom_range(3, 6));
				3: len = 8'($urandom_range(1, 12));
				default: len = 8'($urandom_range(7, 20));
			endcase
			if (phase_no == 1)
				len = 8'd255;
			set_config(len, gain_word($urandom_range(0, 15)), gain_word($urandom_range(0, 15)));
			idle_on = ($urandom_range(0, 3) != 0);
			if (phase_no == 0)
				long_hold_req = 1'b1;
			n = $urandom_range(20, 60);
			repeat (n) push_sample(pick_sample());
			items_sent += n;
			phase_no++;
		end

		// longest block, no idling on either side
		set_config(8'd0, gain_word(15), gain_word(1));
		idle_on = 1'b0;
		repeat (512) push_sample(pick_sample());

		drain_results();
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("dual_channel_adc_averager_unit regression: pass");
		else
			$display("dual_channel_adc_averager_unit regression: fail");
		$finish;
	end

endmodule
